### sv/assert_macros.svh
// Assertion macros shared by the interval index lookup RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication; the consequent may open with a fixed delay.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/iil_pkg.sv
// Shared widths, codes and defaults of the interval index lookup.
package iil_pkg;

    localparam int DEF_MAX_BOUNDS = 32;
    localparam int DEF_KEY_BITS   = 32;

    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;
    localparam int BASE_W  = 16;
    localparam int INDEX_W = 17;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int GROUP = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX     = 2'd1;

endpackage

### sv/iil_table.sv
// Boundary storage and the per-slot compare lanes.
module iil_table
    import iil_pkg::*;
#(
    parameter int MAX_BOUNDS = DEF_MAX_BOUNDS,
    parameter int KEY_BITS   = DEF_KEY_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [SLOT_W-1:0]          wr_slot,
    input  logic signed [KEY_BITS-1:0] wr_value,
    input  logic                       q_valid,
    input  logic signed [KEY_BITS-1:0] q_key,
    input  logic [COUNT_W-1:0]         count,
    output logic                       hit_valid,
    output logic [MAX_BOUNDS-1:0]      hits
);

    localparam int IDX_W = $clog2(MAX_BOUNDS);

    logic signed [KEY_BITS-1:0] bound_reg [MAX_BOUNDS];
    logic                       hit_valid_reg;
    logic [MAX_BOUNDS-1:0]      hits_reg;
    logic [MAX_BOUNDS-1:0]      hits_next;
    logic                       slot_ok;

    assign slot_ok = (32'(wr_slot) < MAX_BOUNDS);

    always_ff @(posedge clk)
    begin
        if (wr_en && slot_ok)
        begin
            bound_reg[IDX_W'(wr_slot)] <= wr_value;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_BOUNDS; i++)
        begin
            hits_next[i] = (32'(count) > i) && (bound_reg[i] <= q_key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            hit_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        hits_reg <= hits_next;
    end

    assign hit_valid = hit_valid_reg;
    assign hits      = hits_reg;

endmodule

### sv/interval_index_lookup.sv
// Top level of the interval index lookup: command port, count pipeline, result strobe.
//
// A beat with opcode write stores key_value in the given slot; the next beat
// already sees it. A query beat gives interval_index = base_index plus the
// number of boundaries among the first boundary_count slots that are at most
// the key. done is high for one cycle per query, set in the last register
// stage below together with interval_index, and stays low for writes.
// busy never rises: one beat is taken every cycle, write or query, and results
// leave in query order. The four register stages are the key register, loaded
// at the accepting edge, the compare lanes over all slots, the group counts of
// eight lanes and the final sum with base_index. Results cannot be held off;
// take them while done is high.
// A query that counts a slot never written since reset gives an undefined
// index.
`include "assert_macros.svh"

module interval_index_lookup
    import iil_pkg::*;
#(
    parameter int MAX_BOUNDS = DEF_MAX_BOUNDS,
    parameter int KEY_BITS   = DEF_KEY_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [SLOT_W-1:0]          slot,
    input  logic signed [KEY_BITS-1:0] key_value,
    output logic                       done,
    output logic [INDEX_W-1:0]         interval_index,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    localparam int NGRP    = (MAX_BOUNDS + GROUP - 1) / GROUP;
    localparam int PAD_W   = NGRP * GROUP;
    localparam int GW      = $clog2(GROUP + 1);
    localparam int CNT_W   = $clog2(MAX_BOUNDS + 1);
    localparam int PIPE_LAT = 4;

    logic                       accept;
    logic                       wr_en;

    logic [COUNT_W-1:0]         boundary_count_reg;
    logic [BASE_W-1:0]          base_index_reg;

    logic                       s0_valid_reg;
    logic signed [KEY_BITS-1:0] s0_key_reg;

    logic                       s1_valid;
    logic [MAX_BOUNDS-1:0]      s1_hits;
    logic [PAD_W-1:0]           s1_hits_pad;

    logic                       s2_valid_reg;
    logic [GW-1:0]              grp_reg  [NGRP];
    logic [GW-1:0]              grp_next [NGRP];

    logic                       done_reg;
    logic [INDEX_W-1:0]         index_reg;
    logic [INDEX_W-1:0]         index_next;
    logic [CNT_W-1:0]           total;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign wr_en  = accept && (opcode == OP_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_count_reg <= '0;
            base_index_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOUNDARY_COUNT: boundary_count_reg <= cfg_data[COUNT_W-1:0];
                REG_BASE_INDEX:     base_index_reg     <= cfg_data[BASE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept && (opcode == OP_QUERY);
        end
    end

    always_ff @(posedge clk)
    begin
        s0_key_reg <= key_value;
    end

    iil_table #(
        .MAX_BOUNDS (MAX_BOUNDS),
        .KEY_BITS   (KEY_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_slot   (slot),
        .wr_value  (key_value),
        .q_valid   (s0_valid_reg),
        .q_key     (s0_key_reg),
        .count     (boundary_count_reg),
        .hit_valid (s1_valid),
        .hits      (s1_hits)
    );

    assign s1_hits_pad = PAD_W'(s1_hits);

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP; j++)
            begin
                grp_next[g] = grp_next[g] + GW'(s1_hits_pad[g * GROUP + j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            total = total + CNT_W'(grp_reg[g]);
        end
        index_next = INDEX_W'(base_index_reg) + INDEX_W'(total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
    end

    assign done           = done_reg;
    assign interval_index = index_reg;

    `ASSERT_IMPLY(a_query_gives_beat, clk, rst_n, accept && (opcode == OP_QUERY), ##PIPE_LAT done)
    `ASSERT_IMPLY(a_no_invented_beat, clk, rst_n, !(accept && (opcode == OP_QUERY)), ##PIPE_LAT !done)
    `ASSERT_NEXT(a_lanes_to_groups, clk, rst_n, s1_valid, s2_valid_reg)

endmodule
